// ----- hdl/vppm_pkg.sv -----
// vppm_pkg: shared widths, register indexes, reset values and the types
// passed between the configuration block, the window evaluator and the core.
// No dependencies.
package vppm_pkg;

    // timer width of the target pwm; period and high values wrap at this width
    localparam int TIMER_W = 16;

    // field and register widths
    localparam int HP_W    = 14;
    localparam int DIM_W   = 10;
    localparam int DUTY_W  = 10;
    localparam int PULSE_W = 16;
    localparam int POS_W   = 7;
    localparam int OUT_W   = 16;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_HALF_PERIOD    = 2'd0;
    localparam logic [1:0] REG_DIM_LEVEL      = 2'd1;
    localparam logic [1:0] REG_DUTY_REDUCTION = 2'd2;

    // dimming position wraps at one hundred
    localparam logic [POS_W-1:0] DIM_WRAP      = 7'd100;
    localparam logic [POS_W-1:0] POS_LAST      = 7'd99;
    localparam logic [POS_W-1:0] POS_NEXT_LAST = 7'd98;

    // reset values of the registers and of the values derived from them
    localparam int HP_RESET       = 100;
    localparam int DIM_RESET      = 500;
    localparam int DUTY_RESET     = 0;
    localparam int HPQ_RESET      = HP_RESET / 5;
    localparam int HPR_RESET      = HP_RESET % 5;
    localparam int K1_RESET       = DIM_RESET / 100;
    localparam int REM_RESET      = DIM_RESET % 100;
    localparam int K2_RESET       = K1_RESET + ((REM_RESET != 0) ? 1 : 0);
    localparam int S_RESET        = 100 - REM_RESET;
    localparam int PULSE_LO_RESET = (2 * HP_RESET * K1_RESET) / 10 - DUTY_RESET;
    localparam int PULSE_HI_RESET = (2 * HP_RESET * K2_RESET) / 10 - DUTY_RESET;

    // settings seen by the window evaluator
    typedef struct packed {
        logic [HP_W-1:0]    half_period;
        logic [POS_W-1:0]   s_point;
        logic [PULSE_W-1:0] pulse_lo;
        logic [PULSE_W-1:0] pulse_hi;
    } vppm_cfg_t;

    // one pwm triplet as formed from a window, period already minus one
    typedef struct packed {
        logic [TIMER_W-1:0] period;
        logic [TIMER_W-1:0] high;
        logic               two;
    } vppm_trip_t;

endpackage

// ----- hdl/vppm_cfg.sv -----
// vppm_cfg: apb register file for half period, dimming level and duty
// reduction, plus the registered pulse widths derived from them.
// Depends on vppm_pkg.
module vppm_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [vppm_pkg::ADDR_W-1:0]  paddr,
    input  logic [vppm_pkg::DATA_W-1:0]  pwdata,
    output logic [vppm_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output vppm_pkg::vppm_cfg_t          cfg
);
    import vppm_pkg::*;

    // reciprocal constants: x/5 for 14-bit x, x/100 for 10-bit x, small x/5
    localparam logic [27:0] DIV5_MUL      = 28'd13108;
    localparam int          DIV5_SHIFT    = 16;
    localparam logic [15:0] DIV100_MUL    = 16'd41;
    localparam int          DIV100_SHIFT  = 12;
    localparam logic [9:0]  SMALL5_MUL    = 10'd13;
    localparam int          SMALL5_SHIFT  = 6;

    logic [HP_W-1:0]    hp_reg;
    logic [DIM_W-1:0]   dim_reg;
    logic [DUTY_W-1:0]  duty_reg;
    logic [11:0]        hpq_reg;
    logic [2:0]         hpr_reg;
    logic [3:0]         k1_reg;
    logic [3:0]         k2_reg;
    logic [POS_W-1:0]   s_reg;
    logic [PULSE_W-1:0] lo_reg;
    logic [PULSE_W-1:0] hi_reg;

    logic               wr;
    logic [1:0]         widx;
    logic [HP_W-1:0]    hp_wr;
    logic [27:0]        hp_prod;
    logic [11:0]        hp_q;
    logic [HP_W-1:0]    hp_r_full;
    logic [DIM_W-1:0]   dim_wr;
    logic [15:0]        dim_prod;
    logic [3:0]         k1_wr;
    logic [DIM_W-1:0]   rem_full;
    logic [POS_W-1:0]   rem_wr;
    logic [PULSE_W-1:0] lo_next;
    logic [PULSE_W-1:0] hi_next;

    // floor(2*hp*k/10) minus duty, clamped at zero; hp = 5*q + r
    function automatic logic [PULSE_W-1:0] pulse_of(
        input logic [11:0]       q,
        input logic [2:0]        r,
        input logic [3:0]        k,
        input logic [DUTY_W-1:0] duty
    );
        logic [15:0] whole;
        logic [5:0]  rk;
        logic [9:0]  rk_scaled;
        logic [16:0] base;
        whole     = 16'(q) * 16'(k);
        rk        = 6'(r) * 6'(k);
        rk_scaled = 10'(rk) * SMALL5_MUL;
        base      = 17'(whole) + 17'(rk_scaled >> SMALL5_SHIFT);
        if (base < 17'(duty))
            return '0;
        return PULSE_W'(base - 17'(duty));
    endfunction

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;
    assign widx   = paddr[ADDR_W-1:2];

    // half period split into quotient and remainder by five
    assign hp_wr     = pwdata[HP_W-1:0];
    assign hp_prod   = 28'(hp_wr) * DIV5_MUL;
    assign hp_q      = hp_prod[DIV5_SHIFT +: 12];
    assign hp_r_full = hp_wr - HP_W'(hp_q) * HP_W'(5);

    // dimming level split into floor fraction and switch point
    assign dim_wr   = pwdata[DIM_W-1:0];
    assign dim_prod = 16'(dim_wr) * DIV100_MUL;
    assign k1_wr    = dim_prod[DIV100_SHIFT +: 4];
    assign rem_full = dim_wr - DIM_W'(k1_wr) * DIM_W'(100);
    assign rem_wr   = rem_full[POS_W-1:0];

    // pulse widths from the registered settings
    assign lo_next = pulse_of(hpq_reg, hpr_reg, k1_reg, duty_reg);
    assign hi_next = pulse_of(hpq_reg, hpr_reg, k2_reg, duty_reg);

    // register file and derived values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hp_reg   <= HP_W'(HP_RESET);
            dim_reg  <= DIM_W'(DIM_RESET);
            duty_reg <= DUTY_W'(DUTY_RESET);
            hpq_reg  <= 12'(HPQ_RESET);
            hpr_reg  <= 3'(HPR_RESET);
            k1_reg   <= 4'(K1_RESET);
            k2_reg   <= 4'(K2_RESET);
            s_reg    <= POS_W'(S_RESET);
            lo_reg   <= PULSE_W'(PULSE_LO_RESET);
            hi_reg   <= PULSE_W'(PULSE_HI_RESET);
        end
        else
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
            if (wr)
            begin
                case (widx)
                    REG_HALF_PERIOD:
                    begin
                        hp_reg  <= hp_wr;
                        hpq_reg <= hp_q;
                        hpr_reg <= hp_r_full[2:0];
                    end
                    REG_DIM_LEVEL:
                    begin
                        dim_reg <= dim_wr;
                        k1_reg  <= k1_wr;
                        k2_reg  <= k1_wr + 4'(rem_wr != '0);
                        s_reg   <= DIM_WRAP - rem_wr;
                    end
                    REG_DUTY_REDUCTION:
                    begin
                        duty_reg <= pwdata[DUTY_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // read back
    always_comb
    begin
        case (widx)
            REG_HALF_PERIOD:    prdata = DATA_W'(hp_reg);
            REG_DIM_LEVEL:      prdata = DATA_W'(dim_reg);
            REG_DUTY_REDUCTION: prdata = DATA_W'(duty_reg);
            default:            prdata = '0;
        endcase
    end

    assign cfg.half_period = hp_reg;
    assign cfg.s_point     = s_reg;
    assign cfg.pulse_lo    = lo_reg;
    assign cfg.pulse_hi    = hi_reg;

endmodule

// ----- hdl/vppm_eval.sv -----
// vppm_eval: turns a full 3-bit look-ahead window into a pwm triplet and
// says whether the window consumes one or two bits. Purely combinational.
// Depends on vppm_pkg.
module vppm_eval (
    input  logic [2:0]                  window,
    input  logic [vppm_pkg::POS_W-1:0]  dim_pos,
    input  vppm_pkg::vppm_cfg_t         cfg,
    output vppm_pkg::vppm_trip_t        trip
);
    import vppm_pkg::*;

    logic               sel1;
    logic               sel2;
    logic               sel3;
    logic [TIMER_W-1:0] m1;
    logic [TIMER_W-1:0] m2;
    logic [TIMER_W-1:0] m3;
    logic [TIMER_W-1:0] hp1;
    logic [TIMER_W-1:0] hp2;
    logic [TIMER_W-1:0] hp4;
    logic [TIMER_W-1:0] per;

    // ceiling fraction once the position reaches the switch point
    assign sel1 = {1'b0, dim_pos} >= {1'b0, cfg.s_point};
    assign sel2 = ({1'b0, dim_pos} + 8'd1 >= {1'b0, cfg.s_point}) && (dim_pos < POS_LAST);
    assign sel3 = ({1'b0, dim_pos} + 8'd2 >= {1'b0, cfg.s_point}) &&
                  (dim_pos < POS_NEXT_LAST);

    assign m1 = TIMER_W'(sel1 ? cfg.pulse_hi : cfg.pulse_lo);
    assign m2 = TIMER_W'(sel2 ? cfg.pulse_hi : cfg.pulse_lo);
    assign m3 = TIMER_W'(sel3 ? cfg.pulse_hi : cfg.pulse_lo);

    assign hp1 = TIMER_W'(cfg.half_period);
    assign hp2 = hp1 << 1;
    assign hp4 = hp1 << 2;

    // period and high width per window pattern, modulo the timer width
    always_comb
    begin
        per       = hp2;
        trip.high = m1;
        trip.two  = 1'b0;
        case (window)
            3'b000, 3'b100:
            begin
                per = hp2;
            end
            3'b010, 3'b110:
            begin
                per = hp4 - m2;
            end
            3'b011, 3'b111:
            begin
                per = hp2 + m1 - m2;
            end
            3'b101:
            begin
                per       = hp4 + m1 - m3;
                trip.high = m1 + m2;
                trip.two  = 1'b1;
            end
            default:
            begin
                // isolated one followed by a zero
                per       = hp2 + m1;
                trip.high = m1 + m2;
                trip.two  = 1'b1;
            end
        endcase
        trip.period = per - TIMER_W'(1);
    end

endmodule

// ----- hdl/vppm_core.sv -----
// vppm_core: input word register, bit window, dimming position, held
// triplet with merge, frame flush sequencer and the output word register.
// Depends on vppm_pkg and vppm_eval.
module vppm_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  vppm_pkg::vppm_cfg_t          cfg,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         data_bit,
    input  logic                         merge_allowed,
    input  logic                         frame_end,
    input  logic [1:0]                   follow_bits,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [vppm_pkg::OUT_W-1:0]   period_value,
    output logic [vppm_pkg::OUT_W-1:0]   repeat_count,
    output logic [vppm_pkg::OUT_W-1:0]   high_width,
    output logic                         last
);
    import vppm_pkg::*;

    typedef enum logic [1:0] {
        FL_NONE,
        FL_EVAL,
        FL_LAST
    } phase_t;

    phase_t             phase_reg,      phase_next;
    logic               in_valid_reg,   in_valid_next;
    logic               bit_reg,        bit_next;
    logic               merge_reg,      merge_next;
    logic               fend_reg,       fend_next;
    logic [1:0]         follow_reg,     follow_next;
    logic [2:0]         win_reg,        win_next;
    logic [1:0]         fill_reg,       fill_next;
    logic [1:0]         pad_reg,        pad_next;
    logic [1:0]         left_reg,       left_next;
    logic [POS_W-1:0]   dim_reg,        dim_next;
    logic               held_valid_reg, held_valid_next;
    logic [TIMER_W-1:0] held_per_reg,   held_per_next;
    logic [TIMER_W-1:0] held_rep_reg,   held_rep_next;
    logic [TIMER_W-1:0] held_high_reg,  held_high_next;
    logic               out_valid_reg,  out_valid_next;
    logic [OUT_W-1:0]   out_per_reg,    out_per_next;
    logic [OUT_W-1:0]   out_rep_reg,    out_rep_next;
    logic [OUT_W-1:0]   out_high_reg,   out_high_next;
    logic               out_last_reg,   out_last_next;

    logic               adv;
    logic               step;
    logic               item_done;
    logic               accept;
    logic [2:0]         wnew;
    logic [1:0]         fnew;
    logic [2:0]         src_w;
    logic [1:0]         src_wf;
    logic [1:0]         src_pad;
    logic [1:0]         left_src;
    logic [2:0]         padded;
    logic [2:0]         pad_idx;
    logic [2:0]         pad_sum;
    logic [1:0]         pad_after;
    logic               do_eval;
    vppm_trip_t         trip;
    logic [1:0]         used;
    logic [1:0]         left_after;
    logic               hit;
    logic [POS_W-1:0]   dim_sum;
    logic [POS_W-1:0]   dim_after;

    // handshake: the core steps whenever it holds an input word and the output register can take a word
    assign adv       = !out_valid_reg || !out_stall;
    assign step      = in_valid_reg && adv;
    assign item_done = step && ((phase_reg == FL_NONE && !fend_reg) || phase_reg == FL_LAST);
    assign in_stall  = in_valid_reg && !item_done;
    assign accept    = in_valid && !in_stall;

    // new bit appended to the window
    assign wnew = win_reg | (3'(bit_reg) << fill_reg);
    assign fnew = fill_reg + 2'd1;

    // window source: live window for a new bit, working window during flush
    assign src_w    = (phase_reg == FL_EVAL) ? win_reg  : wnew;
    assign src_wf   = (phase_reg == FL_EVAL) ? fill_reg : fnew;
    assign src_pad  = (phase_reg == FL_EVAL) ? pad_reg  : 2'd0;
    assign left_src = (phase_reg == FL_EVAL) ? left_reg : fnew;

    // pad empty window slots with the follow bits, then zeros
    always_comb
    begin
        padded  = '0;
        pad_idx = '0;
        for (int p = 0; p < 3; p++)
        begin
            pad_idx = 3'(src_pad) + 3'(p) - 3'(src_wf);
            if (3'(p) < 3'(src_wf))
                padded[p] = src_w[p];
            else if (pad_idx < 3'd2)
                padded[p] = follow_reg[pad_idx[0]];
            else
                padded[p] = 1'b0;
        end
    end

    assign pad_sum   = 3'(src_pad) + 3'd3 - 3'(src_wf);
    assign pad_after = (pad_sum >= 3'd2) ? 2'd2 : pad_sum[1:0];

    assign do_eval = (phase_reg == FL_EVAL) ||
                     (phase_reg == FL_NONE && (fend_reg || fnew == 2'd3));

    vppm_eval u_eval (
        .window  (padded),
        .dim_pos (dim_reg),
        .cfg     (cfg),
        .trip    (trip)
    );

    assign used       = trip.two ? 2'd2 : 2'd1;
    assign left_after = (left_src > used) ? left_src - used : 2'd0;

    // merge with a matching held triplet when merging is allowed, unless its repeat count is full
    assign hit = held_valid_reg && merge_reg && held_per_reg == trip.period &&
                 held_high_reg == trip.high && held_rep_reg != '1;

    // dimming position advance
    assign dim_sum   = dim_reg + POS_W'(used);
    assign dim_after = (dim_sum >= DIM_WRAP) ? dim_sum - DIM_WRAP : dim_sum;

    // next state
    always_comb
    begin
        phase_next      = phase_reg;
        in_valid_next   = in_valid_reg;
        bit_next        = bit_reg;
        merge_next      = merge_reg;
        fend_next       = fend_reg;
        follow_next     = follow_reg;
        win_next        = win_reg;
        fill_next       = fill_reg;
        pad_next        = pad_reg;
        left_next       = left_reg;
        dim_next        = dim_reg;
        held_valid_next = held_valid_reg;
        held_per_next   = held_per_reg;
        held_rep_next   = held_rep_reg;
        held_high_next  = held_high_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_per_next    = out_per_reg;
        out_rep_next    = out_rep_reg;
        out_high_next   = out_high_reg;
        out_last_next   = out_last_reg;

        // input word register
        if (accept)
        begin
            in_valid_next = 1'b1;
            bit_next      = data_bit;
            merge_next    = merge_allowed;
            fend_next     = frame_end;
            follow_next   = follow_bits;
        end
        else if (item_done)
        begin
            in_valid_next = 1'b0;
        end

        if (step && do_eval)
        begin
            // window evaluation, with merge or emit of the held triplet
            if (hit)
            begin
                held_rep_next = held_rep_reg + TIMER_W'(1);
            end
            else
            begin
                if (held_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_per_next   = OUT_W'(held_per_reg);
                    out_rep_next   = OUT_W'(held_rep_reg);
                    out_high_next  = OUT_W'(held_high_reg);
                    out_last_next  = 1'b0;
                end
                held_valid_next = 1'b1;
                held_per_next   = trip.period;
                held_rep_next   = '0;
                held_high_next  = trip.high;
            end
            dim_next  = dim_after;
            win_next  = padded >> used;
            fill_next = trip.two ? 2'd1 : 2'd2;
            if (fend_reg)
            begin
                pad_next   = pad_after;
                left_next  = left_after;
                phase_next = (left_after == 2'd0) ? FL_LAST : FL_EVAL;
            end
        end
        else if (step && phase_reg == FL_NONE)
        begin
            // window not yet full
            win_next  = wnew;
            fill_next = fnew;
        end
        else if (step && phase_reg == FL_LAST)
        begin
            // final triplet of the frame, then start fresh
            if (held_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_per_next   = OUT_W'(held_per_reg);
                out_rep_next   = OUT_W'(held_rep_reg);
                out_high_next  = OUT_W'(held_high_reg);
                out_last_next  = 1'b1;
            end
            held_valid_next = 1'b0;
            win_next        = '0;
            fill_next       = '0;
            dim_next        = '0;
            phase_next      = FL_NONE;
        end
    end

    // state and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= FL_NONE;
            in_valid_reg   <= 1'b0;
            bit_reg        <= 1'b0;
            merge_reg      <= 1'b0;
            fend_reg       <= 1'b0;
            follow_reg     <= '0;
            win_reg        <= '0;
            fill_reg       <= '0;
            pad_reg        <= '0;
            left_reg       <= '0;
            dim_reg        <= '0;
            held_valid_reg <= 1'b0;
            held_per_reg   <= '0;
            held_rep_reg   <= '0;
            held_high_reg  <= '0;
            out_valid_reg  <= 1'b0;
            out_per_reg    <= '0;
            out_rep_reg    <= '0;
            out_high_reg   <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            in_valid_reg   <= in_valid_next;
            bit_reg        <= bit_next;
            merge_reg      <= merge_next;
            fend_reg       <= fend_next;
            follow_reg     <= follow_next;
            win_reg        <= win_next;
            fill_reg       <= fill_next;
            pad_reg        <= pad_next;
            left_reg       <= left_next;
            dim_reg        <= dim_next;
            held_valid_reg <= held_valid_next;
            held_per_reg   <= held_per_next;
            held_rep_reg   <= held_rep_next;
            held_high_reg  <= held_high_next;
            out_valid_reg  <= out_valid_next;
            out_per_reg    <= out_per_next;
            out_rep_reg    <= out_rep_next;
            out_high_reg   <= out_high_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign period_value = out_per_reg;
    assign repeat_count = out_rep_reg;
    assign high_width   = out_high_reg;
    assign last         = out_last_reg;

`ifndef NO_ASSERTIONS
    // the live window never holds three unconsumed bits between steps
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg != 2'd3)
        else $error("window fill reached three");

    // dimming position stays inside its wrap range
    a_dim_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dim_reg < DIM_WRAP)
        else $error("dimming position out of range");

    // a flush only runs while the frame-end word is held
    a_flush_item: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != FL_NONE) |-> (in_valid_reg && fend_reg))
        else $error("flush running without a frame-end word");

    // the final phase always has a triplet to flush
    a_last_held: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == FL_LAST) |-> held_valid_reg)
        else $error("flush reached the end with nothing held");

    // a word marked last leaves the core idle for the next frame
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg == FL_LAST) |=> (!held_valid_reg && fill_reg == 2'd0 &&
                                            dim_reg == '0))
        else $error("state not cleared after frame flush");
`endif

endmodule

// ----- hdl/vppm_pulse_triplet_modulator_top.sv -----
// vppm_pulse_triplet_modulator_top: top level of the vppm triplet modulator.
// Depends on vppm_pkg, vppm_cfg, vppm_core (and vppm_eval below it).
//
// Takes one line-coded bit per word and produces pwm timer triplets (period
// minus one, repeat count, high width) for a light-source driver. An ordinary
// bit is taken every cycle while the output side keeps up; a bit marked as
// frame end occupies the block for one to three window evaluations of the
// flush plus a final step for the last triplet, because the flush sequencer
// in the core does one window a cycle while the output side keeps up and the
// single output register carries at most one word a cycle. The bit that
// releases a result word from the held slot is captured in the input word
// register and the word is then registered in the output word register;
// during a flush further words come from the later flush steps. Register
// writes take effect for a bit accepted from the cycle after the write; the
// pulse widths are re-derived in a register stage behind the apb registers.
module vppm_pulse_triplet_modulator_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [vppm_pkg::ADDR_W-1:0]  paddr,
    input  logic [vppm_pkg::DATA_W-1:0]  pwdata,
    output logic [vppm_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         data_bit,
    input  logic                         merge_allowed,
    input  logic                         frame_end,
    input  logic [1:0]                   follow_bits,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [vppm_pkg::OUT_W-1:0]   period_value,
    output logic [vppm_pkg::OUT_W-1:0]   repeat_count,
    output logic [vppm_pkg::OUT_W-1:0]   high_width,
    output logic                         last
);
    import vppm_pkg::*;

    vppm_cfg_t cfg;

    // configuration registers and derived pulse widths
    vppm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // bit window, merge and flush datapath
    vppm_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_bit      (data_bit),
        .merge_allowed (merge_allowed),
        .frame_end     (frame_end),
        .follow_bits   (follow_bits),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .period_value  (period_value),
        .repeat_count  (repeat_count),
        .high_width    (high_width),
        .last          (last)
    );

endmodule
